[rtl/core/lpmr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed message ring.
// No dependencies; the interfaces, the engine and the top level refer to it by scoped names.
package lpmr_pkg;

  localparam int unsigned DEF_MAX_CAPACITY = 1024;
  localparam int unsigned CAP_RESET        = 1024;
  localparam int unsigned CAP_MIN          = 8;
  localparam int unsigned HDR_BYTES        = 4;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned FREE_W   = 11;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_START_WRITE = 2'd0,
    OP_PAYLOAD     = 2'd1,
    OP_START_READ  = 2'd2,
    OP_READ_BYTE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_SEQ     = 2'd3
  } status_t;

  // What the RAM read data register holds for the pending result
  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_LEN  = 2'd1,
    RD_BYTE = 2'd2
  } rd_kind_t;

  typedef struct packed {
    op_t                op;
    logic [LEN_W-1:0]   msg_length;
    logic [BYTE_W-1:0]  data_byte;
    logic [LEN_W-1:0]   recv_limit;
  } in_item_t;

  typedef struct packed {
    status_t  status;
    logic     kept;
    logic     last;
    rd_kind_t kind;
    logic     swap;   // odd byte address: low byte sits in bank 1
  } res_ctl_t;

  typedef struct packed {
    logic we0;
    logic we1;
    logic re0;
    logic re1;
  } mem_ctl_t;

endpackage

[rtl/core/lpmr_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the message ring: valid/ready and one operation beat.
// Depends on lpmr_pkg for field widths.
interface lpmr_req_if;
  logic                             valid;
  logic                             ready;
  logic [lpmr_pkg::OP_W-1:0]        op;
  logic [lpmr_pkg::LEN_W-1:0]       msg_length;
  logic [lpmr_pkg::BYTE_W-1:0]      data_byte;
  logic [lpmr_pkg::LEN_W-1:0]       recv_limit;

  modport source (output valid, output op, output msg_length, output data_byte,
                  output recv_limit, input ready);
  modport sink   (input valid, input op, input msg_length, input data_byte,
                  input recv_limit, output ready);
endinterface

[rtl/core/lpmr_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel of the message ring: valid/ready and one result beat.
// Depends on lpmr_pkg for field widths.
interface lpmr_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [lpmr_pkg::STATUS_W-1:0]      status;
  logic [lpmr_pkg::LEN_W-1:0]         length_out;
  logic [lpmr_pkg::BYTE_W-1:0]        data_out;
  logic                               kept;
  logic                               last;
  logic signed [lpmr_pkg::FREE_W-1:0] free_bytes;
  logic                               ring_empty;

  modport source (output valid, output status, output length_out, output data_out,
                  output kept, output last, output free_bytes, output ring_empty,
                  input ready);
  modport sink   (input valid, input status, input length_out, input data_out,
                  input kept, input last, input free_bytes, input ring_empty,
                  output ready);
endinterface

[rtl/core/lpmr_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module lpmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/lpmr_engine.sv]
`timescale 1ns / 1ps
// Ring pointer state, sequencing checks and RAM request generation.
// Depends on lpmr_pkg; drives the two byte banks instantiated in the top level.
module lpmr_engine #(
  parameter int unsigned MAX_CAPACITY = lpmr_pkg::DEF_MAX_CAPACITY,
  parameter int unsigned BW           = $clog2(MAX_CAPACITY) - 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lpmr_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                              item_valid,
  input  lpmr_pkg::in_item_t                item,
  input  logic                              adv,
  input  logic [lpmr_pkg::LEN_W-1:0]        hdr_len,
  output lpmr_pkg::res_ctl_t                res_ctl,
  output lpmr_pkg::mem_ctl_t                mem_ctl,
  output logic [BW-1:0]                     idx0,
  output logic [BW-1:0]                     idx1,
  output logic [lpmr_pkg::BYTE_W-1:0]       wd0,
  output logic [lpmr_pkg::BYTE_W-1:0]       wd1,
  output logic signed [lpmr_pkg::FREE_W-1:0] free_bytes,
  output logic                              ring_empty
);

  localparam int unsigned PW = $clog2(MAX_CAPACITY);
  localparam int unsigned CW = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned LW = lpmr_pkg::LEN_W;
  localparam int unsigned FW = ((CW > LW + 1) ? CW : LW + 1) + 1;
  localparam int unsigned XW = (CW > lpmr_pkg::CFG_W) ? CW : lpmr_pkg::CFG_W;
  localparam int unsigned CAP_RST = (lpmr_pkg::CAP_RESET > MAX_CAPACITY) ?
                                    MAX_CAPACITY : lpmr_pkg::CAP_RESET;

  logic [CW-1:0] cap;
  logic [PW-1:0] cw_ptr, cw_ptr_next;
  logic [PW-1:0] ww_ptr, ww_ptr_next;
  logic [LW-1:0] wr_rem, wr_rem_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [LW-1:0] rd_rem, rd_rem_next;
  logic [LW-1:0] rd_pos, rd_pos_next;
  logic [LW-1:0] rd_lim, rd_lim_next;
  logic          len_pend, len_pend_next;

  logic [CW-1:0]        cap_cfg;
  logic [CW-1:0]        used;
  logic signed [FW-1:0] free_s;
  logic                 room_ok;
  logic [LW-1:0]        rr_eff;
  logic [PW-1:0]        p_wr, p_rd, p_wr_adv, p_rd_adv, ww_inc, rd_inc, addr;
  lpmr_pkg::mem_ctl_t   mem_req;

  // Clamp the capacity once at write time
  always_comb begin
    if (XW'(cfg_wr_data) < XW'(lpmr_pkg::CAP_MIN)) begin
      cap_cfg = CW'(lpmr_pkg::CAP_MIN);
    end else if (XW'(cfg_wr_data) > XW'(MAX_CAPACITY)) begin
      cap_cfg = CW'(MAX_CAPACITY);
    end else begin
      cap_cfg = CW'(cfg_wr_data);
    end
  end

  // Occupancy from committed pointers; state is stable while a result waits
  assign used = (cw_ptr >= rd_ptr) ? (CW'(cw_ptr) - CW'(rd_ptr))
                                   : (CW'(cw_ptr) + cap - CW'(rd_ptr));
  assign free_s     = $signed(FW'(cap) - FW'(used) - FW'(lpmr_pkg::HDR_BYTES));
  assign room_ok    = free_s >= $signed(FW'(item.msg_length) + FW'(lpmr_pkg::HDR_BYTES));
  assign free_bytes = free_s[lpmr_pkg::FREE_W-1:0];
  assign ring_empty = (cw_ptr == rd_ptr);

  // Header length of the last start read is still in the RAM read register
  assign rr_eff = len_pend ? hdr_len : rd_rem;

  // Headers never split: jump to zero when the tail is too short
  assign p_wr = ((cap - CW'(cw_ptr)) < CW'(lpmr_pkg::HDR_BYTES)) ? '0 : cw_ptr;
  assign p_rd = ((cap - CW'(rd_ptr)) < CW'(lpmr_pkg::HDR_BYTES)) ? '0 : rd_ptr;
  assign p_wr_adv = ((CW'(p_wr) + CW'(lpmr_pkg::HDR_BYTES)) == cap) ? '0 :
                    PW'(p_wr + PW'(lpmr_pkg::HDR_BYTES));
  assign p_rd_adv = ((CW'(p_rd) + CW'(lpmr_pkg::HDR_BYTES)) == cap) ? '0 :
                    PW'(p_rd + PW'(lpmr_pkg::HDR_BYTES));
  assign ww_inc = ((CW'(ww_ptr) + CW'(1)) == cap) ? '0 : PW'(ww_ptr + PW'(1));
  assign rd_inc = ((CW'(rd_ptr) + CW'(1)) == cap) ? '0 : PW'(rd_ptr + PW'(1));

  always_comb begin
    cw_ptr_next   = cw_ptr;
    ww_ptr_next   = ww_ptr;
    wr_rem_next   = wr_rem;
    rd_ptr_next   = rd_ptr;
    rd_rem_next   = rr_eff;
    rd_pos_next   = rd_pos;
    rd_lim_next   = rd_lim;
    len_pend_next = 1'b0;
    res_ctl       = '{status: lpmr_pkg::ST_OK, kept: 1'b0, last: 1'b0,
                      kind: lpmr_pkg::RD_NONE, swap: 1'b0};
    mem_req       = '0;
    addr          = '0;
    wd0           = item.data_byte;
    wd1           = item.data_byte;

    case (item.op)
      lpmr_pkg::OP_START_WRITE: begin
        if (wr_rem != '0) begin
          res_ctl.status = lpmr_pkg::ST_SEQ;
        end else if (!room_ok) begin
          res_ctl.status = lpmr_pkg::ST_NO_ROOM;
        end else begin
          addr        = p_wr;
          mem_req.we0 = 1'b1;
          mem_req.we1 = 1'b1;
          wd0 = p_wr[0] ? item.msg_length[15:8] : item.msg_length[7:0];
          wd1 = p_wr[0] ? item.msg_length[7:0]  : item.msg_length[15:8];
          ww_ptr_next = p_wr_adv;
          wr_rem_next = item.msg_length;
          if (item.msg_length == '0) begin
            cw_ptr_next = p_wr_adv;
          end
        end
      end
      lpmr_pkg::OP_PAYLOAD: begin
        if (wr_rem == '0) begin
          res_ctl.status = lpmr_pkg::ST_SEQ;
        end else begin
          addr        = ww_ptr;
          mem_req.we0 = !ww_ptr[0];
          mem_req.we1 = ww_ptr[0];
          ww_ptr_next = ww_inc;
          wr_rem_next = wr_rem - LW'(1);
          if (wr_rem == LW'(1)) begin
            cw_ptr_next  = ww_inc;
            res_ctl.last = 1'b1;
          end
        end
      end
      lpmr_pkg::OP_START_READ: begin
        if (rr_eff != '0) begin
          res_ctl.status = lpmr_pkg::ST_SEQ;
        end else if (cw_ptr == rd_ptr) begin
          res_ctl.status = lpmr_pkg::ST_EMPTY;
        end else begin
          addr          = p_rd;
          mem_req.re0   = 1'b1;
          mem_req.re1   = 1'b1;
          res_ctl.kind  = lpmr_pkg::RD_LEN;
          res_ctl.swap  = p_rd[0];
          rd_ptr_next   = p_rd_adv;
          rd_pos_next   = '0;
          rd_lim_next   = item.recv_limit;
          len_pend_next = 1'b1;
        end
      end
      lpmr_pkg::OP_READ_BYTE: begin
        if (rr_eff == '0) begin
          res_ctl.status = lpmr_pkg::ST_SEQ;
        end else begin
          addr         = rd_ptr;
          mem_req.re0  = !rd_ptr[0];
          mem_req.re1  = rd_ptr[0];
          res_ctl.kind = lpmr_pkg::RD_BYTE;
          res_ctl.swap = rd_ptr[0];
          res_ctl.kept = rd_pos < rd_lim;
          res_ctl.last = (rr_eff == LW'(1));
          rd_ptr_next  = rd_inc;
          rd_pos_next  = rd_pos + LW'(1);
          rd_rem_next  = rr_eff - LW'(1);
        end
      end
      default: begin
        res_ctl.status = lpmr_pkg::ST_SEQ;
      end
    endcase
  end

  // Bank 1 holds odd addresses; a header at an odd address spills into the next even row
  assign idx1 = addr[PW-1:1];
  assign idx0 = addr[PW-1:1] + BW'(addr[0]);

  assign mem_ctl = '{we0: mem_req.we0 && adv && item_valid,
                     we1: mem_req.we1 && adv && item_valid,
                     re0: mem_req.re0 && adv && item_valid,
                     re1: mem_req.re1 && adv && item_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      cap      <= CW'(CAP_RST);
      cw_ptr   <= '0;
      ww_ptr   <= '0;
      wr_rem   <= '0;
      rd_ptr   <= '0;
      rd_rem   <= '0;
      rd_pos   <= '0;
      rd_lim   <= '0;
      len_pend <= 1'b0;
    end else if (cfg_wr_en) begin
      cap      <= cap_cfg;
      cw_ptr   <= '0;
      ww_ptr   <= '0;
      wr_rem   <= '0;
      rd_ptr   <= '0;
      rd_rem   <= '0;
      rd_pos   <= '0;
      rd_lim   <= '0;
      len_pend <= 1'b0;
    end else if (adv && item_valid) begin
      cw_ptr   <= cw_ptr_next;
      ww_ptr   <= ww_ptr_next;
      wr_rem   <= wr_rem_next;
      rd_ptr   <= rd_ptr_next;
      rd_rem   <= rd_rem_next;
      rd_pos   <= rd_pos_next;
      rd_lim   <= rd_lim_next;
      len_pend <= len_pend_next;
    end
  end

endmodule

[rtl/core/length_prefixed_message_ring_core.sv]
`timescale 1ns / 1ps
// Top level of the length-prefixed message ring: input register, result register,
// two RAM byte banks. Depends on lpmr_pkg, lpmr_req_if, lpmr_rsp_if, lpmr_ram, lpmr_engine.
//
// Byte ring of up to MAX_CAPACITY bytes holding messages behind 4-byte length
// headers. One operation beat is accepted every clock cycle unless results back up; its
// result passes through the input register and then the result register, and further
// beats keep flowing while a result waits, until both registers are full. The store is
// split into even and odd byte banks, each with one write and one registered read
// port, so a header's two length bytes are written or read in the same cycle. The
// store needs no clearing pass after reset or a capacity write; the ring is empty
// then and no unwritten byte is ever read.
// Writing capacity_in_use clamps it to 8..MAX_CAPACITY and empties the ring; write
// it only when no result is outstanding.
module length_prefixed_message_ring_core #(
  parameter int unsigned MAX_CAPACITY = lpmr_pkg::DEF_MAX_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [lpmr_pkg::CFG_W-1:0] cfg_wr_data,
  lpmr_req_if.sink                   req,
  lpmr_rsp_if.source                 rsp
);

  localparam int unsigned BW = $clog2(MAX_CAPACITY) - 1;
  localparam int unsigned BD = (MAX_CAPACITY + 1) / 2;

  logic                        req_valid_q;
  lpmr_pkg::in_item_t          req_q;
  logic                        rsp_valid_q;
  lpmr_pkg::res_ctl_t          res_q;
  lpmr_pkg::res_ctl_t          res_ctl;
  lpmr_pkg::mem_ctl_t          mem_ctl;
  logic                        adv;
  logic                        accept;
  logic [BW-1:0]               idx0, idx1;
  logic [lpmr_pkg::BYTE_W-1:0] wd0, wd1, rd0, rd1;
  logic [lpmr_pkg::LEN_W-1:0]  hdr_len;

  // Advance when the result register is free or being drained this cycle
  assign adv       = req_valid_q && (!rsp_valid_q || rsp.ready);
  assign req.ready = !req_valid_q || adv;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        req_valid_q <= 1'b1;
      end else if (adv) begin
        req_valid_q <= 1'b0;
      end
      if (adv) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= '{op: lpmr_pkg::op_t'(req.op), msg_length: req.msg_length,
                 data_byte: req.data_byte, recv_limit: req.recv_limit};
    end
    if (adv) begin
      res_q <= res_ctl;
    end
  end

  lpmr_engine #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .BW           (BW)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (req_valid_q),
    .item        (req_q),
    .adv         (adv),
    .hdr_len     (hdr_len),
    .res_ctl     (res_ctl),
    .mem_ctl     (mem_ctl),
    .idx0        (idx0),
    .idx1        (idx1),
    .wd0         (wd0),
    .wd1         (wd1),
    .free_bytes  (rsp.free_bytes),
    .ring_empty  (rsp.ring_empty)
  );

  lpmr_ram #(
    .WIDTH (lpmr_pkg::BYTE_W),
    .DEPTH (BD)
  ) u_bank_even (
    .clk   (clk),
    .we    (mem_ctl.we0),
    .waddr (idx0),
    .wdata (wd0),
    .re    (mem_ctl.re0),
    .raddr (idx0),
    .rdata (rd0)
  );

  lpmr_ram #(
    .WIDTH (lpmr_pkg::BYTE_W),
    .DEPTH (BD)
  ) u_bank_odd (
    .clk   (clk),
    .we    (mem_ctl.we1),
    .waddr (idx1),
    .wdata (wd1),
    .re    (mem_ctl.re1),
    .raddr (idx1),
    .rdata (rd1)
  );

  // Low header byte comes from the odd bank when the header starts at an odd address
  assign hdr_len = res_q.swap ? {rd0, rd1} : {rd1, rd0};

  assign rsp.valid      = rsp_valid_q;
  assign rsp.status     = res_q.status;
  assign rsp.kept       = res_q.kept;
  assign rsp.last       = res_q.last;
  assign rsp.length_out = (res_q.kind == lpmr_pkg::RD_LEN) ? hdr_len : '0;
  assign rsp.data_out   = (res_q.kind == lpmr_pkg::RD_BYTE) ? (res_q.swap ? rd1 : rd0) : '0;

  // RAM is only touched by a beat that moves into the result register
  a_mem_on_adv: assert property (@(posedge clk) disable iff (rst)
    (mem_ctl.we0 || mem_ctl.we1 || mem_ctl.re0 || mem_ctl.re1) |-> adv)
    else $error("RAM access without pipeline advance");

  // Read data is only presented for accepted reads
  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid_q && res_q.kind != lpmr_pkg::RD_NONE) |-> (res_q.status == lpmr_pkg::ST_OK))
    else $error("read data flagged on a rejected beat");

  // An empty-ring rejection must report an empty ring
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid_q && res_q.status == lpmr_pkg::ST_EMPTY) |-> rsp.ring_empty)
    else $error("empty status with non-empty ring");

  // A capacity write empties the ring
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> rsp.ring_empty)
    else $error("ring not empty after capacity write");

endmodule
